// ===== hw/rtl/pvp_pkg.sv =====
// Shared types and constants for the point view projection block.
// Request/result payloads, command and register codes, MAC pipe records.
// No dependencies.
package pvp_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD_MV = 2'd0;
    localparam logic [1:0] CMD_LOAD_PJ = 2'd1;
    localparam logic [1:0] CMD_XFORM   = 2'd2;

    // viewport register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_VP_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VP_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 2'd3;

    // datapath widths
    localparam int unsigned OP_W   = 33;  // multiplier operand
    localparam int unsigned ACC_W  = 66;  // product / accumulator
    localparam int unsigned NUM_W  = 49;  // viewport numerator, signed
    localparam int unsigned DEN_W  = 33;  // 2*clip_w, signed
    localparam int unsigned QMAG_W = 48;  // quotient magnitude

    // MAC result destination kinds
    localparam logic [1:0] KIND_EYE  = 2'd0;
    localparam logic [1:0] KIND_CLIP = 2'd1;
    localparam logic [1:0] KIND_NUM  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } pvp_req_t;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               w_zero;
        logic               saturated;
    } pvp_res_t;

    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic                  a_mem;   // A operand from matrix memory
        logic [1:0]            kind;
        logic [1:0]            row;
        logic signed [OP_W-1:0] a_alt;
        logic signed [OP_W-1:0] b;
    } pvp_mac_op_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [1:0]        row;
        logic              sat;
        logic [31:0]       val32;
        logic [NUM_W-1:0]  num;
    } pvp_mac_res_t;

endpackage

// ===== hw/rtl/pvp_matrix_mem.sv =====
// Matrix store: modelview (entries 0-15) and projection (16-31), 32 x 32 bit.
// Synchronous, registered read; unwritten entries read as identity.
// Depends on nothing.
module pvp_matrix_mem #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [4:0]  raddr,
    output logic [31:0] rdata
);
    localparam int unsigned ENTRIES = 32;
    localparam logic [31:0] IDENT_ONE = 32'd1 << FRAC_BITS;

    logic [31:0]        mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        rdata_reg;
    logic [31:0]        ident_val;

    // diagonal when row == column
    assign ident_val = (raddr[1:0] == raddr[3:2]) ? IDENT_ONE : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : ident_val;
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pvp_mac.sv =====
// Shared multiply-accumulate pipe: operand select, 33x33 multiply,
// 66-bit accumulate, then shift/clamp or pass of the sum. Uses pvp_pkg.
module pvp_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pvp_pkg::pvp_mac_op_t  op,
    input  logic [31:0]           mem_rdata,
    output pvp_pkg::pvp_mac_res_t res,
    output logic                  busy
);
    import pvp_pkg::*;

    pvp_mac_op_t             s1_op_reg;
    logic                    s1_valid_reg;
    logic                    s2_valid_reg;
    logic                    s2_first_reg;
    logic                    s2_last_reg;
    logic [1:0]              s2_kind_reg;
    logic [1:0]              s2_row_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                    s3_valid_reg;
    logic [1:0]              s3_kind_reg;
    logic [1:0]              s3_row_reg;
    logic signed [OP_W-1:0]  a_op;
    logic signed [ACC_W-1:0] acc_shift;
    logic [32:0]             clamped;

    function automatic logic [32:0] clamp32(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (v[ACC_W-1:31] == {(ACC_W-31){v[31]}});
        if (fits)
            return {1'b0, v[31:0]};
        else if (v[ACC_W-1])
            return {1'b1, 32'h8000_0000};
        else
            return {1'b1, 32'h7FFF_FFFF};
    endfunction

    // stage 1: memory data is valid here
    assign a_op      = s1_op_reg.a_mem ? $signed({mem_rdata[31], mem_rdata}) : s1_op_reg.a_alt;
    assign prod_next = a_op * s1_op_reg.b;

    // stage 2: accumulate
    assign acc_next  = (s2_first_reg ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= op.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= op;
        prod_reg     <= prod_next;
        s2_first_reg <= s1_op_reg.first;
        s2_last_reg  <= s1_op_reg.last;
        s2_kind_reg  <= s1_op_reg.kind;
        s2_row_reg   <= s1_op_reg.row;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        s3_kind_reg <= s2_kind_reg;
        s3_row_reg  <= s2_row_reg;
    end

    // stage 3: post-process the finished sum
    assign acc_shift = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        unique case (s3_kind_reg)
            KIND_EYE:  clamped = clamp32(acc_reg);
            KIND_CLIP: clamped = clamp32(acc_shift);
            default:   clamped = {1'b0, acc_reg[31:0]};
        endcase
        res.valid = s3_valid_reg;
        res.kind  = s3_kind_reg;
        res.row   = s3_row_reg;
        res.sat   = clamped[32];
        res.val32 = clamped[31:0];
        res.num   = acc_reg[NUM_W-1:0];
    end

    assign busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;

endmodule

// ===== hw/rtl/pvp_divider.sv =====
// Radix-2 restoring divider, truncating toward zero, one quotient bit a cycle.
// Sign and magnitude out. Uses pvp_pkg widths.
module pvp_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [pvp_pkg::NUM_W-1:0]   num,
    input  logic signed [pvp_pkg::DEN_W-1:0]   den,
    output logic                               done,
    output logic                               q_neg,
    output logic [pvp_pkg::QMAG_W-1:0]         q_mag
);
    import pvp_pkg::*;

    localparam int unsigned CNT_W = $clog2(QMAG_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QMAG_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [QMAG_W-1:0] quo_reg;
    logic [QMAG_W-1:0] quo_next;
    logic [NUM_W-1:0]  num_abs;
    logic [DEN_W-1:0]  den_abs;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    assign trial    = {rem_reg, quo_reg[QMAG_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign quo_next = {quo_reg[QMAG_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_LAST)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
            den_reg <= den_abs;
            rem_reg <= '0;
            quo_reg <= num_abs[QMAG_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done  = done_reg;
    assign q_neg = neg_reg;
    assign q_mag = quo_reg;

endmodule

// ===== hw/rtl/point_view_projection.sv =====
// Point view projection: modelview, projection and viewport transform of an
// integer point (x, y, 0, 1), Q16.16 matrices.
// Uses pvp_pkg, pvp_matrix_mem, pvp_mac, pvp_divider.
//
// Request channel (req_valid / req_stall / req_data) carries three commands:
//   load modelview entry, load projection entry: written in the cycle the
//     request is taken, no result, block ready again the next cycle;
//   transform point: one result on res_valid / res_stall / res_data.
// Unknown command codes are taken and dropped.
// A transform spends its time in the single shared MAC pipe (12 modelview
// terms, 16 projection terms and 4 viewport terms, each group drained before
// the next) and in two 48-step divisions, one quotient bit per cycle, through
// one divider; a zero clip w skips the viewport terms and divisions.
// One transform is in flight at a time; req_stall is high while it runs.
// Viewport registers go through cfg_we / cfg_index / cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// Reset: both matrices read as identity, viewport 0, 0, 1024, 768.
// A stalled result is held in the output register; the block keeps taking
// requests, and a following transform waits at its end until the slot frees.
module point_view_projection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  pvp_pkg::pvp_req_t                  req_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output pvp_pkg::pvp_res_t                  res_data,
    input  logic                               cfg_we,
    input  logic [pvp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pvp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pvp_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_EYE       = 4'd1;
    localparam logic [3:0] ST_EYE_WAIT  = 4'd2;
    localparam logic [3:0] ST_CLIP      = 4'd3;
    localparam logic [3:0] ST_CLIP_WAIT = 4'd4;
    localparam logic [3:0] ST_MAP       = 4'd5;
    localparam logic [3:0] ST_MAP_WAIT  = 4'd6;
    localparam logic [3:0] ST_DIV_X     = 4'd7;
    localparam logic [3:0] ST_DIV_Y     = 4'd8;
    localparam logic [3:0] ST_OUT       = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         row_reg, row_next;
    logic [1:0]         term_reg, term_next;

    // viewport
    logic signed [15:0] vp_left_reg;
    logic signed [15:0] vp_bottom_reg;
    logic [14:0]        vp_width_reg;
    logic [14:0]        vp_height_reg;

    // per-transform working values
    logic signed [15:0] px_reg, py_reg;
    logic [31:0]        eye_reg  [4];
    logic [31:0]        clip_reg [4];
    logic [NUM_W-1:0]   num_x_reg, num_y_reg;
    logic signed [15:0] sx_reg, sy_reg;
    logic               sat_reg;
    logic               wz_reg;

    logic               res_valid_reg;
    pvp_res_t           res_data_reg;

    logic               req_fire;
    logic               xform_fire;
    logic               mem_we;
    logic [4:0]         mem_waddr;
    logic [4:0]         mem_raddr;
    logic [31:0]        mem_rdata;

    pvp_mac_op_t        mac_op;
    pvp_mac_res_t       mac_res;
    logic               mac_busy;

    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic               div_neg;
    logic [QMAG_W-1:0]  div_mag;

    logic               sx_load, sy_load, wz_set, res_load;
    logic signed [15:0] q_clamped;
    logic               q_clip;
    logic signed [OP_W-1:0] cw33;
    logic signed [OP_W-1:0] cxy33;
    logic signed [15:0]     org;
    logic [14:0]            size;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_fire   = req_valid && !req_stall;
    assign xform_fire = req_fire && (req_data.cmd == CMD_XFORM);

    // Loads land only while idle and the MAC uses reads only while busy, so a
    // read that the MAC uses never meets a write to the matrix store.
    assign mem_we    = req_fire &&
                       (req_data.cmd == CMD_LOAD_MV || req_data.cmd == CMD_LOAD_PJ);
    assign mem_waddr = {req_data.cmd == CMD_LOAD_PJ, req_data.entry_index};

    pvp_matrix_mem #(.FRAC_BITS(FRAC_BITS)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req_data.entry_value),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pvp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (mac_op),
        .mem_rdata (mem_rdata),
        .res       (mac_res),
        .busy      (mac_busy)
    );

    // divisor is 2*clip_w
    assign div_den = {clip_reg[3], 1'b0};

    pvp_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .q_neg (div_neg),
        .q_mag (div_mag)
    );

    // clamp the quotient to 16 bits signed
    always_comb
    begin
        if (div_neg)
        begin
            q_clip    = (div_mag > QMAG_W'(32768));
            q_clamped = q_clip ? 16'sh8000 : $signed(16'(-div_mag[15:0]));
        end
        else
        begin
            q_clip    = (div_mag > QMAG_W'(32767));
            q_clamped = q_clip ? 16'sh7FFF : $signed(div_mag[15:0]);
        end
    end

    // viewport operands for the current axis (term bit 1 picks y)
    assign cw33  = {clip_reg[3][31], clip_reg[3]};
    assign cxy33 = term_reg[1] ? {clip_reg[1][31], clip_reg[1]}
                               : {clip_reg[0][31], clip_reg[0]};
    assign org   = term_reg[1] ? vp_bottom_reg : vp_left_reg;
    assign size  = term_reg[1] ? vp_height_reg : vp_width_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        term_next  = term_reg;
        mac_op     = '0;
        mem_raddr  = '0;
        div_start  = 1'b0;
        div_num    = num_x_reg;
        sx_load    = 1'b0;
        sy_load    = 1'b0;
        wz_set     = 1'b0;
        res_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (xform_fire)
                begin
                    state_next = ST_EYE;
                    row_next   = '0;
                    term_next  = '0;
                end
            end

            // eye[r] = x*MV[r] + y*MV[4+r] + MV[12+r]
            ST_EYE:
            begin
                mac_op.valid = 1'b1;
                mac_op.a_mem = 1'b1;
                mac_op.first = (term_reg == 2'd0);
                mac_op.last  = (term_reg == 2'd2);
                mac_op.kind  = KIND_EYE;
                mac_op.row   = row_reg;
                unique case (term_reg)
                    2'd0:    mac_op.b = OP_W'(px_reg);
                    2'd1:    mac_op.b = OP_W'(py_reg);
                    default: mac_op.b = OP_W'(1);
                endcase
                mem_raddr = {1'b0, (term_reg == 2'd2) ? 2'd3 : term_reg, row_reg};
                if (term_reg == 2'd2)
                begin
                    term_next = '0;
                    row_next  = row_reg + 1'b1;
                    if (row_reg == 2'd3)
                        state_next = ST_EYE_WAIT;
                end
                else
                begin
                    term_next = term_reg + 1'b1;
                end
            end

            ST_EYE_WAIT:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_CLIP;
                    row_next   = '0;
                    term_next  = '0;
                end
            end

            // clip[r] = sum_j P[r+4j] * eye[j], then floor shift in the MAC
            ST_CLIP:
            begin
                mac_op.valid = 1'b1;
                mac_op.a_mem = 1'b1;
                mac_op.first = (term_reg == 2'd0);
                mac_op.last  = (term_reg == 2'd3);
                mac_op.kind  = KIND_CLIP;
                mac_op.row   = row_reg;
                mac_op.b     = OP_W'($signed(eye_reg[term_reg]));
                mem_raddr    = {1'b1, term_reg, row_reg};
                term_next    = term_reg + 1'b1;
                if (term_reg == 2'd3)
                begin
                    row_next = row_reg + 1'b1;
                    if (row_reg == 2'd3)
                        state_next = ST_CLIP_WAIT;
                end
            end

            ST_CLIP_WAIT:
            begin
                if (!mac_busy)
                begin
                    term_next = '0;
                    if (clip_reg[3] == 32'd0)
                    begin
                        wz_set     = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MAP;
                    end
                end
            end

            // num = cw * (2*org) + size * (c + cw), x then y
            ST_MAP:
            begin
                mac_op.valid = 1'b1;
                mac_op.a_mem = 1'b0;
                mac_op.first = !term_reg[0];
                mac_op.last  = term_reg[0];
                mac_op.kind  = KIND_NUM;
                mac_op.row   = {1'b0, term_reg[1]};
                if (!term_reg[0])
                begin
                    mac_op.a_alt = cw33;
                    mac_op.b     = OP_W'($signed({org, 1'b0}));
                end
                else
                begin
                    mac_op.a_alt = cxy33 + cw33;
                    mac_op.b     = $signed({{(OP_W-15){1'b0}}, size});
                end
                term_next = term_reg + 1'b1;
                if (term_reg == 2'd3)
                    state_next = ST_MAP_WAIT;
            end

            ST_MAP_WAIT:
            begin
                if (!mac_busy)
                begin
                    div_start  = 1'b1;
                    div_num    = num_x_reg;
                    state_next = ST_DIV_X;
                end
            end

            ST_DIV_X:
            begin
                if (div_done)
                begin
                    sx_load    = 1'b1;
                    div_start  = 1'b1;
                    div_num    = num_y_reg;
                    state_next = ST_DIV_Y;
                end
            end

            ST_DIV_Y:
            begin
                if (div_done)
                begin
                    sy_load    = 1'b1;
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and viewport registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            term_reg      <= '0;
            res_valid_reg <= 1'b0;
            vp_left_reg   <= '0;
            vp_bottom_reg <= '0;
            vp_width_reg  <= 15'd1024;
            vp_height_reg <= 15'd768;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            term_reg  <= term_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_VP_LEFT:   vp_left_reg   <= $signed(cfg_data);
                    REG_VP_BOTTOM: vp_bottom_reg <= $signed(cfg_data);
                    REG_VP_WIDTH:  vp_width_reg  <= cfg_data[14:0];
                    REG_VP_HEIGHT: vp_height_reg <= cfg_data[14:0];
                endcase
            end
        end
    end

    // working values and output payload
    always_ff @(posedge clk)
    begin
        if (xform_fire)
        begin
            px_reg  <= req_data.point_x;
            py_reg  <= req_data.point_y;
            sat_reg <= 1'b0;
            wz_reg  <= 1'b0;
        end
        else
        begin
            if (wz_set)
                wz_reg <= 1'b1;
            if ((mac_res.valid && mac_res.sat) || ((sx_load || sy_load) && q_clip))
                sat_reg <= 1'b1;
        end

        if (mac_res.valid)
        begin
            unique case (mac_res.kind)
                KIND_EYE:  eye_reg[mac_res.row]  <= mac_res.val32;
                KIND_CLIP: clip_reg[mac_res.row] <= mac_res.val32;
                default:
                begin
                    if (mac_res.row[0])
                        num_y_reg <= mac_res.num;
                    else
                        num_x_reg <= mac_res.num;
                end
            endcase
        end

        if (sx_load)
            sx_reg <= q_clamped;
        if (sy_load)
            sy_reg <= q_clamped;

        // zero w forces coordinates and the saturation flag to zero
        if (res_load)
        begin
            res_data_reg.screen_x  <= wz_reg ? 16'sd0 : sx_reg;
            res_data_reg.screen_y  <= wz_reg ? 16'sd0 : sy_reg;
            res_data_reg.w_zero    <= wz_reg;
            res_data_reg.saturated <= wz_reg ? 1'b0 : sat_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== hw/rtl/pvp_checker.sv =====
// Port-level checks for point_view_projection, attached by bind.
// Uses pvp_pkg for payload types and command codes.
module pvp_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  pvp_pkg::pvp_req_t              req_data,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  pvp_pkg::pvp_res_t              res_data
);
    import pvp_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // a zero-w result carries zero coordinates and no saturation
    a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.w_zero |->
            res_data.screen_x == 16'sd0 && res_data.screen_y == 16'sd0 &&
            !res_data.saturated)
        else $error("zero-w result with nonzero payload");

    // loads and unknown commands never block the next request
    a_load_nostall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.cmd != CMD_XFORM |=> !req_stall)
        else $error("stall after a load");

    // a transform occupies the block, and a new result only follows work
    a_xform_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.cmd == CMD_XFORM |=> req_stall)
        else $error("no stall after transform request");

    a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_stall))
        else $error("result appeared while idle");

endmodule

bind point_view_projection pvp_checker u_pvp_checker (.*);
